// File: hdl/dht_pkg.sv
// Shared types and constants for the single-wire sensor reader.
package dht_pkg;

    localparam int CNT_W      = 20;
    localparam int NUM_BYTES  = 5;
    localparam int FRAME_BITS = NUM_BYTES * 8;

    localparam logic [CNT_W-1:0] CNT_MAX         = '1;
    localparam logic [3:0]       FIRST_BYTE_BITS = 4'd10;
    localparam logic [3:0]       BYTE_BITS       = 4'd8;
    localparam logic [2:0]       LAST_BYTE       = 3'(NUM_BYTES - 1);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    localparam logic [1:0] CFG_STROBE    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [CNT_W-1:0] RST_STROBE    = 20'd2000;
    localparam logic [CNT_W-1:0] RST_TIMEOUT   = 20'd200;
    localparam logic [CNT_W-1:0] RST_THRESHOLD = 20'd50;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_STROBE = 2'd1,
        PH_LISTEN = 2'd2
    } t_phase;

    typedef struct packed {
        logic action;
        logic line_level;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] strobe_ticks;
        logic [CNT_W-1:0] timeout_ticks;
        logic [CNT_W-1:0] one_threshold_ticks;
    } t_cfg;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } t_result;

endpackage

// File: hdl/dht_in_reg.sv
// Input register stage: holds one accepted tick until the core consumes it.
module dht_in_reg
    import dht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/dht_core.sv
// Protocol state machine, bit shifter, checksum and result formatting.
module dht_core
    import dht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase                r_phase, n_phase;
    logic [CNT_W-1:0]      r_elapsed, n_elapsed;
    logic                  r_prev, n_prev;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [2:0]            r_byte_idx, n_byte_idx;
    logic [3:0]            r_bits_rem, n_bits_rem;
    logic [7:0]            r_sum, n_sum;
    logic [15:0]           r_hum, n_hum;
    logic [15:0]           r_temp, n_temp;
    logic [1:0]            r_status, n_status;

    logic                  cnt_sat;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  edge_seen;
    logic                  falling;
    logic                  bit_val;
    logic [FRAME_BITS-1:0] shift_nxt;
    logic [3:0]            bits_dec;
    logic                  byte_end;
    logic                  last_byte;
    logic                  frame_end;
    logic                  timed_out;
    logic [15:0]           mag;
    logic                  drive;
    logic                  done;

    assign cnt_sat   = (r_elapsed == CNT_MAX);
    assign cnt_inc   = cnt_sat ? r_elapsed : r_elapsed + 20'd1;
    assign edge_seen = (i_item.line_level != r_prev);
    assign falling   = edge_seen && !i_item.line_level;
    assign bit_val   = (r_elapsed > i_cfg.one_threshold_ticks);
    assign shift_nxt = {r_shift[FRAME_BITS-2:0], bit_val};
    assign bits_dec  = r_bits_rem - 4'd1;
    assign byte_end  = (bits_dec == 4'd0);
    assign last_byte = (r_byte_idx >= LAST_BYTE);
    assign frame_end = falling && byte_end && last_byte;
    assign timed_out = !edge_seen && (cnt_inc >= i_cfg.timeout_ticks);
    // Bytes 2 and 3 form a sign-magnitude temperature once the last bit is in.
    assign mag       = {1'b0, shift_nxt[22:16], shift_nxt[15:8]};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_item.action) begin
            n_phase = PH_STROBE;
        end else begin
            unique case (r_phase)
                PH_STROBE: begin
                    if (cnt_inc >= i_cfg.strobe_ticks) begin
                        n_phase = PH_LISTEN;
                    end
                end
                PH_LISTEN: begin
                    if (frame_end || timed_out) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Datapath and per-tick outputs.
    always_comb begin
        n_elapsed  = r_elapsed;
        n_prev     = r_prev;
        n_shift    = r_shift;
        n_byte_idx = r_byte_idx;
        n_bits_rem = r_bits_rem;
        n_sum      = r_sum;
        n_hum      = r_hum;
        n_temp     = r_temp;
        n_status   = r_status;
        drive      = 1'b0;
        done       = 1'b0;
        if (i_item.action) begin
            n_elapsed  = '0;
            n_prev     = 1'b1;
            n_byte_idx = '0;
            n_bits_rem = FIRST_BYTE_BITS;
            n_sum      = '0;
            drive      = 1'b1;
        end else begin
            unique case (r_phase)
                PH_STROBE: begin
                    if (cnt_inc >= i_cfg.strobe_ticks) begin
                        n_elapsed = '0;
                        n_prev    = 1'b1;
                    end else begin
                        n_elapsed = cnt_inc;
                        drive     = 1'b1;
                    end
                end
                PH_LISTEN: begin
                    if (edge_seen) begin
                        n_prev    = i_item.line_level;
                        n_elapsed = '0;
                        if (falling) begin
                            n_shift    = shift_nxt;
                            n_bits_rem = bits_dec;
                            if (byte_end) begin
                                n_bits_rem = BYTE_BITS;
                                if (last_byte) begin
                                    n_hum    = shift_nxt[39:24];
                                    n_temp   = shift_nxt[23] ? 16'(16'd0 - mag) : mag;
                                    n_status = (shift_nxt[7:0] == r_sum) ? STATUS_OK
                                                                         : STATUS_CHECKSUM;
                                    done     = 1'b1;
                                end else begin
                                    n_sum      = r_sum + shift_nxt[7:0];
                                    n_byte_idx = r_byte_idx + 3'd1;
                                end
                            end
                        end
                    end else begin
                        n_elapsed = cnt_inc;
                        if (timed_out) begin
                            n_status = STATUS_TIMEOUT;
                            done     = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result.drive_low   = drive;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.status      = n_status;
        o_result.humidity    = n_hum;
        o_result.temperature = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_elapsed  <= '0;
            r_prev     <= 1'b1;
            r_byte_idx <= '0;
            r_bits_rem <= FIRST_BYTE_BITS;
            r_sum      <= '0;
            r_hum      <= '0;
            r_temp     <= '0;
            r_status   <= STATUS_OK;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_prev     <= n_prev;
            r_byte_idx <= n_byte_idx;
            r_bits_rem <= n_bits_rem;
            r_sum      <= n_sum;
            r_hum      <= n_hum;
            r_temp     <= n_temp;
            r_status   <= n_status;
        end
    end

    // Received bits need no reset: every bit is overwritten before it is used.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_shift <= n_shift;
        end
    end

endmodule

// File: hdl/dht_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module dht_out_reg
    import dht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = i_in_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hdl/dht22_single_wire_reader_unit.sv
// Top level of the single-wire humidity and temperature sensor reader.
//
//  Channel   | Direction | Payload
//  ----------+-----------+-------------------------------------------------------
//  s_axis    | in        | tdata: line_level; tuser: action (1 = start)
//  m_axis    | out       | tdata: drive_low, busy_res, done_res, status,
//            |           |        humidity, temperature
//  cfg write | in        | i_cfg_index selects strobe, timeout or threshold
//
// Each input transaction is one timer tick and produces exactly one output
// transaction. A tick passes an input register, then one step of the protocol
// logic (counter increment and compare, bit shift, checksum add) into the
// result register: one tick per cycle sustained while the output is not
// stalled, set by the single-step state update. Reset is synchronous and
// active low and loads the configuration defaults. A stall on the output holds
// the result register and, through it, the protocol state; the input register
// takes at most one more tick before s_axis_tready falls.
module dht22_single_wire_reader_unit
    import dht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input ticks.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [0] line_level, [7:1] zero
    input  logic [0:0]          s_axis_tuser,   // [0] action
    // Results.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // [0] drive_low, [1] busy_res,
                                                // [2] done_res, [4:3] status,
                                                // [20:5] humidity,
                                                // [36:21] temperature, [39:37] zero
    // Configuration writes.
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CNT_W-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   core_item;
    logic    core_valid;
    logic    advance;
    t_result core_result;
    t_result out_result;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe_ticks        <= RST_STROBE;
            r_cfg.timeout_ticks       <= RST_TIMEOUT;
            r_cfg.one_threshold_ticks <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STROBE:    r_cfg.strobe_ticks        <= i_cfg_data;
                CFG_TIMEOUT:   r_cfg.timeout_ticks       <= i_cfg_data;
                CFG_THRESHOLD: r_cfg.one_threshold_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_item.action     = s_axis_tuser[0];
    assign in_item.line_level = s_axis_tdata[0];

    dht_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (core_valid),
        .o_item    (core_item)
    );

    // The core state only moves when a tick is handed to the result register.
    dht_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_item   (core_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    dht_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(core_valid),
        .i_result  (core_result),
        .i_ready   (m_axis_tready),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .o_result  (out_result)
    );

    assign m_axis_tdata = {3'b000,
                           out_result.temperature,
                           out_result.humidity,
                           out_result.status,
                           out_result.done_res,
                           out_result.busy_res,
                           out_result.drive_low};

endmodule

// File: bench/dht22_single_wire_reader_unit_tb.sv
// Self-checking testbench for the single-wire humidity and temperature sensor reader.
`timescale 1ns / 1ps

module dht22_single_wire_reader_unit_tb;
    import dht_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;     // [0] line_level, [7:1] zero
    logic [0:0]       s_axis_tuser;     // [0] action
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [39:0]      m_axis_tdata;     // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [4:3] status, [20:5] humidity,
                                        // [36:21] temperature, [39:37] zero
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [CNT_W-1:0] i_cfg_data;

    dht22_single_wire_reader_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the sensor reader: configuration and protocol state.
    t_cfg             reg_cfg;
    t_phase           rd_phase;
    logic [CNT_W-1:0] rd_ticks;
    logic             rd_last_level;
    logic [7:0]       rd_bytes [NUM_BYTES];
    logic [2:0]       rd_byte_idx;
    logic [3:0]       rd_bits_left;
    logic [7:0]       rd_sum;
    logic [15:0]      hold_humidity;
    logic [15:0]      hold_temperature;
    logic [1:0]       hold_status;

    // Readings predicted for accepted ticks, oldest first.
    t_result pending_readings [$];

    int  mismatch_count;
    int  ticks_sent;
    int  cycle_count;
    int  hold_request;
    bit  gaps_on;

    t_result got_reading;
    t_result want_reading;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic reset_predictor();
        reg_cfg.strobe_ticks        = RST_STROBE;
        reg_cfg.timeout_ticks       = RST_TIMEOUT;
        reg_cfg.one_threshold_ticks = RST_THRESHOLD;
        rd_phase         = PH_IDLE;
        rd_ticks         = '0;
        rd_last_level    = 1'b1;
        for (int i = 0; i < NUM_BYTES; i++) rd_bytes[i] = 8'd0;
        rd_byte_idx      = '0;
        rd_bits_left     = FIRST_BYTE_BITS;
        rd_sum           = 8'd0;
        hold_humidity    = 16'd0;
        hold_temperature = 16'd0;
        hold_status      = STATUS_OK;
    endtask

    // One timer tick of the reader; returns the transaction it emits.
    function automatic t_result predict_reading(input logic act, input logic lvl);
        t_result     r;
        logic [7:0]  b;
        logic [14:0] mag;
        r = '0;
        if (act) begin
            rd_phase      = PH_STROBE;
            rd_ticks      = '0;
            rd_last_level = 1'b1;
            rd_byte_idx   = '0;
            rd_bits_left  = FIRST_BYTE_BITS;
            rd_sum        = 8'd0;
            r.drive_low   = 1'b1;
        end else if (rd_phase == PH_STROBE) begin
            if (rd_ticks != CNT_MAX) rd_ticks = rd_ticks + 1'b1;
            if (rd_ticks >= reg_cfg.strobe_ticks) begin
                // Release the line; the pull-up brings it high.
                rd_phase      = PH_LISTEN;
                rd_ticks      = '0;
                rd_last_level = 1'b1;
            end else begin
                r.drive_low = 1'b1;
            end
        end else if (rd_phase == PH_LISTEN) begin
            if (lvl != rd_last_level) begin
                rd_last_level = lvl;
                if (!lvl) begin
                    // A falling edge closes a high pulse: long pulses read as one.
                    b = {rd_bytes[rd_byte_idx][6:0],
                         (rd_ticks > reg_cfg.one_threshold_ticks)};
                    rd_bytes[rd_byte_idx] = b;
                    rd_bits_left = rd_bits_left - 1'b1;
                    if (rd_bits_left == 4'd0) begin
                        rd_bits_left = BYTE_BITS;
                        if (rd_byte_idx == LAST_BYTE) begin
                            hold_humidity = {rd_bytes[0], rd_bytes[1]};
                            mag = {rd_bytes[2][6:0], rd_bytes[3]};
                            hold_temperature = rd_bytes[2][7] ? 16'd0 - {1'b0, mag}
                                                              : {1'b0, mag};
                            hold_status = (rd_bytes[4] == rd_sum) ? STATUS_OK
                                                                  : STATUS_CHECKSUM;
                            rd_phase  = PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            rd_sum      = rd_sum + b;
                            rd_byte_idx = rd_byte_idx + 1'b1;
                        end
                    end
                end
                rd_ticks = '0;
            end else begin
                if (rd_ticks != CNT_MAX) rd_ticks = rd_ticks + 1'b1;
                if (rd_ticks >= reg_cfg.timeout_ticks) begin
                    hold_status = STATUS_TIMEOUT;
                    rd_phase    = PH_IDLE;
                    r.done_res  = 1'b1;
                end
            end
        end
        r.busy_res    = (rd_phase != PH_IDLE);
        r.status      = hold_status;
        r.humidity    = hold_humidity;
        r.temperature = hold_temperature;
        return r;
    endfunction

    // Result side: compare every accepted transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_reading.drive_low   = m_axis_tdata[0];
            got_reading.busy_res    = m_axis_tdata[1];
            got_reading.done_res    = m_axis_tdata[2];
            got_reading.status      = m_axis_tdata[4:3];
            got_reading.humidity    = m_axis_tdata[20:5];
            got_reading.temperature = m_axis_tdata[36:21];
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction, tdata %h", m_axis_tdata);
            end else begin
                want_reading = pending_readings.pop_front();
                if (got_reading !== want_reading || m_axis_tdata[39:37] !== 3'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected drive %b busy %b done %b status %0d hum %h temp %h",
                                 want_reading.drive_low, want_reading.busy_res,
                                 want_reading.done_res, want_reading.status,
                                 want_reading.humidity, want_reading.temperature);
                        $display("          got drive %b busy %b done %b status %0d hum %h temp %h pad %b",
                                 got_reading.drive_low, got_reading.busy_res,
                                 got_reading.done_res, got_reading.status,
                                 got_reading.humidity, got_reading.temperature,
                                 m_axis_tdata[39:37]);
                    end
                end
            end
        end
    end

    // Result side ready: random stall bursts, plus one long hold-off on request.
    initial begin : result_ready
        int stall_left;
        int hold_left;
        m_axis_tready = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one tick, wait until it is accepted, and record the predicted reading.
    task automatic send_tick(input logic act, input logic lvl);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, lvl};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_readings.push_back(predict_reading(act, lvl));
        ticks_sent++;
    endtask

    task automatic send_level(input logic lvl, input int n);
        repeat (n) send_tick(1'b0, lvl);
    endtask

    // Stop offering ticks and let every outstanding reading come back.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_STROBE:    reg_cfg.strobe_ticks        = val;
            CFG_TIMEOUT:   reg_cfg.timeout_ticks       = val;
            CFG_THRESHOLD: reg_cfg.one_threshold_ticks = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [CNT_W-1:0] strobe, input logic [CNT_W-1:0] tmo,
                                input logic [CNT_W-1:0] thr);
        wait_idle();
        write_reg(CFG_STROBE, strobe);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // High pulse length in ticks that the reader decodes as the given bit.
    // The elapsed count at the closing falling edge is the length minus one.
    function automatic int high_len(input logic bit_val);
        int thr;
        int tmo;
        int n;
        thr = int'(reg_cfg.one_threshold_ticks);
        tmo = int'(reg_cfg.timeout_ticks);
        if (bit_val) begin
            n = thr + 2 + $urandom_range(0, 2);
            if (n > tmo) n = tmo;
        end else begin
            n = (thr + 1 < 3) ? thr + 1 : 3;
            n = $urandom_range(1, n);
        end
        return n;
    endfunction

    // Frame contents {byte0 .. byte4}, biased toward the interesting corners.
    function automatic logic [39:0] frame_content();
        logic [7:0] b [4];
        logic [7:0] sum;
        int         mode;
        for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
        mode = $urandom_range(0, 5);
        if (mode == 4) begin
            b[2] = 8'h80;   // negative zero temperature
            b[3] = 8'h00;
        end else if (mode == 5) begin
            b[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b[1] = b[0];
            b[2] = $urandom_range(0, 1) ? 8'hFF : 8'h7F;
            b[3] = 8'hFF;
        end
        sum = b[0] + b[1] + b[2] + b[3];
        if (mode == 3) sum = sum + 8'($urandom_range(1, 255));
        return {b[0], b[1], b[2], b[3], sum};
    endfunction

    // Start, strobe, response pulses, then the first cut data bits, MSB first.
    task automatic send_frame(input logic [39:0] frame_bits, input int cut);
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (int'(reg_cfg.strobe_ticks)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        send_level(1'b1, $urandom_range(0, 2));
        send_level(1'b0, $urandom_range(1, 3));
        send_level(1'b1, $urandom_range(1, 3));
        for (int i = 0; i < cut; i++) begin
            send_level(1'b0, $urandom_range(1, 3));
            send_level(1'b1, high_len(frame_bits[39 - i]));
        end
        if (cut == 40) send_level(1'b0, $urandom_range(1, 3));
    endtask

    // Reset values of the held outputs, on idle ticks at both line levels.
    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // Shortest strobe and timeout, zero threshold, and a start while busy.
    task automatic test_short_strobe_and_restart();
        apply_config(20'd1, 20'd1, 20'd0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // Longest strobe: the line stays driven until a new start abandons it.
    task automatic test_long_strobe();
        apply_config(CNT_MAX, RST_TIMEOUT, RST_THRESHOLD);
        send_tick(1'b1, 1'b1);
        repeat (4) send_tick(1'b0, 1'($urandom_range(0, 1)));
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // Mostly well-formed frames, with some cut short, timed out or drowned in noise.
    task automatic test_random_frames(input int budget);
        int stop_at;
        int cut;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(3, 10))
                        send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
                end
                1: begin
                    cut = $urandom_range(0, 39);
                    send_frame(frame_content(), cut);
                    if (reg_cfg.timeout_ticks <= 20 && $urandom_range(0, 1))
                        send_level(1'b1, int'(reg_cfg.timeout_ticks));
                end
                default: send_frame(frame_content(), 40);
            endcase
        end
    endtask

    // A sweep of settings, the zero threshold among them.
    task automatic test_config_sweep();
        logic [CNT_W-1:0] thr;
        for (int p = 0; p < 2; p++) begin
            thr = (p == 0) ? 20'd0 : 20'($urandom_range(0, 4));
            apply_config(20'($urandom_range(1, 5)), thr + 20'($urandom_range(5, 12)), thr);
            gaps_on = 1'b1;
            test_random_frames(1);
        end
    endtask

    // Largest threshold and timeout: no pulse is long enough to read as one.
    task automatic test_threshold_max();
        apply_config(20'd3, CNT_MAX, CNT_MAX);
        gaps_on = 1'b1;
        send_frame(40'd0, 40);
    endtask

    // The result side holds off long enough for the input to back up; the
    // partial frame then ends in a timeout.
    task automatic test_output_stall();
        apply_config(20'd2, 20'd12, 20'd2);
        gaps_on = 1'b0;
        hold_request = 80;
        send_frame(frame_content(), 20);
        send_level(1'b1, int'(reg_cfg.timeout_ticks));
    endtask

    // Closing stretch at full rate on both sides: a partial frame and a timeout.
    task automatic test_full_rate();
        apply_config(20'd1, 20'd8, 20'd1);
        gaps_on = 1'b0;
        send_frame(frame_content(), 12);
        send_level(1'b1, int'(reg_cfg.timeout_ticks));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        s_axis_tuser   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_STROBE;
        i_cfg_data     = '0;
        gaps_on        = 1'b0;
        hold_request   = 0;
        mismatch_count = 0;
        ticks_sent     = 0;
        reset_predictor();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on = 1'b1;
        test_reset_defaults();
        test_short_strobe_and_restart();
        test_long_strobe();
        test_config_sweep();
        test_threshold_max();
        test_output_stall();
        test_full_rate();
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/dht_pkg.sv
hdl/dht_in_reg.sv
hdl/dht_core.sv
hdl/dht_out_reg.sv
hdl/dht22_single_wire_reader_unit.sv
bench/dht22_single_wire_reader_unit_tb.sv
